@@ hw/rtl/tlvp_pkg.sv @@
// Shared types and constants for the TLV header field parser.
package tlvp_pkg;

    // One header byte request and the start-of-header marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_header;
    } t_in_req;

    // One extracted field result.
    typedef struct packed {
        logic [1:0]  field_index;
        logic [1:0]  item_kind;
        logic [31:0] data_value;
        logic        last_of_field;
        logic        header_done;
    } t_out_res;

    // Tag bytes recognized during the scan.
    localparam logic [7:0] TAG_STRING  = 8'd26;
    localparam logic [7:0] TAG_INTEGER = 8'd2;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_INT   = 2'd2;

    // Number of elements in one header.
    localparam logic [2:0] NUM_ELEMENTS = 3'd4;

endpackage

@@ hw/rtl/tlv_header_field_parser_top.sv @@
// TLV header field parser: input register, decode logic and result register.
//
// Accepts one header byte per clock cycle and returns at most one result per
// byte: the input register holds each byte, then the decode logic writes the
// result register. An element whose kind fits its slot yields results: a string
// one per content byte (or one empty-string result), an integer one on its last
// content byte. start_of_header restarts the parse on that byte. The
// sustained rate of one byte per cycle is held as long as the consumer takes
// results; a stalled result register stalls the input register behind it.
// No clearing pass is needed after reset.
module tlv_header_field_parser_top
    import tlvp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int INTEGER_WIDTH    = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_res o_out_res
);

    logic     in_valid;
    t_in_req  in_req;
    logic     can_take;
    logic     step;
    logic     res_valid;
    t_out_res res;

    // A held request advances when the result register has room.
    assign step = in_valid && can_take;

    // Input register.
    tlvp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .i_take  (step),
        .o_valid (in_valid),
        .o_req   (in_req)
    );

    // Parse state and decode.
    tlvp_core #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .INTEGER_WIDTH    (INTEGER_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_req       (in_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    tlvp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_take  (can_take),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_res       (o_out_res)
    );

endmodule

@@ hw/rtl/tlvp_in_stage.sv @@
// Input register stage holding one accepted header byte request.
module tlvp_in_stage
    import tlvp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in_req i_req,
    input  logic    i_take,
    output logic    o_valid,
    output t_in_req o_req
);

    logic    r_valid;
    t_in_req r_req;

    // The slot frees up whenever the held request moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

@@ hw/rtl/tlvp_core.sv @@
// Parse state and per-byte TLV decode logic.
module tlvp_core
    import tlvp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int INTEGER_WIDTH    = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_req  i_req,
    output logic     o_res_valid,
    output t_out_res o_res
);

    localparam int LenW = $clog2(MAX_LENGTH_BYTES + 1);
    localparam logic [6:0] MaxLen7 = 7'(MAX_LENGTH_BYTES);
    localparam logic [LenW-1:0] MaxLen = LenW'(MAX_LENGTH_BYTES);

    // Parse phases.
    localparam logic [2:0] PH_SCAN     = 3'd0;
    localparam logic [2:0] PH_STR_LEN  = 3'd1;
    localparam logic [2:0] PH_STR_LENB = 3'd2;
    localparam logic [2:0] PH_STR_BODY = 3'd3;
    localparam logic [2:0] PH_INT_LEN  = 3'd4;
    localparam logic [2:0] PH_INT_BODY = 3'd5;
    localparam logic [2:0] PH_DONE     = 3'd6;

    logic [2:0]               r_phase, n_phase, cur_phase;
    logic [2:0]               r_count, n_count, cur_count;
    logic                     r_is_int, n_is_int, cur_is_int;
    logic [LenW-1:0]          r_len_left, n_len_left, cur_len_left;
    logic [31:0]              r_content, n_content, cur_content;
    logic [INTEGER_WIDTH-1:0] r_acc, n_acc, cur_acc;

    logic                     finish;
    logic [1:0]               fin_kind;
    logic [31:0]              fin_value;
    logic                     wanted;
    logic                     done;
    logic [6:0]               long_cnt;
    logic [2:0]               count_inc;
    logic [INTEGER_WIDTH+31:0] acc_ext;

    // A start-of-header request sees the reset state.
    always_comb begin
        if (i_req.start_of_header) begin
            cur_phase    = PH_SCAN;
            cur_count    = '0;
            cur_is_int   = 1'b0;
            cur_len_left = '0;
            cur_content  = '0;
            cur_acc      = '0;
        end else begin
            cur_phase    = r_phase;
            cur_count    = r_count;
            cur_is_int   = r_is_int;
            cur_len_left = r_len_left;
            cur_content  = r_content;
            cur_acc      = r_acc;
        end
    end

    // Element kind matches its slot: strings first, then integers.
    assign wanted = cur_is_int ? (cur_count == 3'd2 || cur_count == 3'd3)
                               : (cur_count < 3'd2);
    assign count_inc = cur_count + 3'd1;
    assign done      = (count_inc >= NUM_ELEMENTS);
    assign long_cnt  = i_req.data_byte[6:0];
    assign acc_ext   = {32'd0, n_acc};

    // Per-byte decode.
    always_comb begin
        n_phase     = cur_phase;
        n_count     = cur_count;
        n_is_int    = cur_is_int;
        n_len_left  = cur_len_left;
        n_content   = cur_content;
        n_acc       = cur_acc;
        finish      = 1'b0;
        fin_kind    = KIND_CHAR;
        fin_value   = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (cur_phase)
            PH_SCAN: begin
                if (i_req.data_byte == TAG_STRING) begin
                    n_is_int = 1'b0;
                    n_phase  = PH_STR_LEN;
                end else if (i_req.data_byte == TAG_INTEGER) begin
                    n_is_int = 1'b1;
                    n_phase  = PH_INT_LEN;
                end
            end
            PH_STR_LEN: begin
                n_content = '0;
                if (i_req.data_byte[7]) begin
                    if (long_cnt == 7'd0) begin
                        finish   = 1'b1;
                        fin_kind = KIND_EMPTY;
                    end else begin
                        n_len_left = (long_cnt > MaxLen7) ? MaxLen : long_cnt[LenW-1:0];
                        n_phase    = PH_STR_LENB;
                    end
                end else begin
                    n_content = {24'd0, i_req.data_byte};
                    if (i_req.data_byte == 8'd0) begin
                        finish   = 1'b1;
                        fin_kind = KIND_EMPTY;
                    end else begin
                        n_phase = PH_STR_BODY;
                    end
                end
            end
            PH_STR_LENB: begin
                n_content = {cur_content[23:0], i_req.data_byte};
                if (cur_len_left != '0) begin
                    n_len_left = cur_len_left - LenW'(1);
                end
                if (n_len_left == '0) begin
                    if (n_content == 32'd0) begin
                        finish   = 1'b1;
                        fin_kind = KIND_EMPTY;
                    end else begin
                        n_phase = PH_STR_BODY;
                    end
                end
            end
            PH_STR_BODY: begin
                if (cur_content <= 32'd1) begin
                    n_content = '0;
                    finish    = 1'b1;
                    fin_kind  = KIND_CHAR;
                    fin_value = {24'd0, i_req.data_byte};
                end else begin
                    n_content   = cur_content - 32'd1;
                    o_res_valid = wanted;
                    o_res.field_index   = cur_count[1:0];
                    o_res.item_kind     = KIND_CHAR;
                    o_res.data_value    = {24'd0, i_req.data_byte};
                    o_res.last_of_field = 1'b0;
                    o_res.header_done   = 1'b0;
                end
            end
            PH_INT_LEN: begin
                n_acc     = '0;
                n_content = {24'd0, i_req.data_byte};
                if (i_req.data_byte == 8'd0) begin
                    finish   = 1'b1;
                    fin_kind = KIND_INT;
                end else begin
                    n_phase = PH_INT_BODY;
                end
            end
            PH_INT_BODY: begin
                n_acc = INTEGER_WIDTH'({cur_acc, i_req.data_byte});
                if (cur_content <= 32'd1) begin
                    n_content = '0;
                    finish    = 1'b1;
                    fin_kind  = KIND_INT;
                    fin_value = acc_ext[31:0];
                end else begin
                    n_content = cur_content - 32'd1;
                end
            end
            default: begin
                // Header complete: ignore bytes until the next start.
            end
        endcase

        // Close the element and report it if its kind fits its slot.
        if (finish) begin
            n_count     = count_inc;
            n_phase     = done ? PH_DONE : PH_SCAN;
            o_res_valid = wanted;
            o_res.field_index   = cur_count[1:0];
            o_res.item_kind     = fin_kind;
            o_res.data_value    = fin_value;
            o_res.last_of_field = 1'b1;
            o_res.header_done   = done;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SCAN;
            r_count    <= '0;
            r_is_int   <= 1'b0;
            r_len_left <= '0;
            r_content  <= '0;
            r_acc      <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_is_int   <= n_is_int;
            r_len_left <= n_len_left;
            r_content  <= n_content;
            r_acc      <= n_acc;
        end
    end

`ifndef NO_ASSERTIONS
    // The element count never passes the number of elements.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NUM_ELEMENTS)
        else $error("element count out of range");

    // The done phase is reached only after the fourth element.
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_count == NUM_ELEMENTS))
        else $error("done phase with too few elements");

    // Header completion is flagged only on the last result of field three.
    a_done_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.header_done) |->
            (o_res.field_index == 2'd3 && o_res.last_of_field))
        else $error("header done on wrong result");

    // Integer results are single and always final.
    a_int_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.item_kind == KIND_INT) |->
            o_res.last_of_field)
        else $error("integer result not final");
`endif

endmodule

@@ hw/rtl/tlvp_out_stage.sv @@
// Result register stage toward the downstream consumer.
module tlvp_out_stage
    import tlvp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_res_valid,
    input  t_out_res i_res,
    output logic     o_can_take,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_res o_res
);

    logic     r_valid;
    t_out_res r_res;

    // Room exists when empty or when the held result leaves this cycle.
    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result capture.
    always_ff @(posedge i_clk) begin
        if (i_step && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the TLV header field parser.
`timescale 1ns / 100ps

module tb_top;
    import tlvp_pkg::*;

    localparam int MAX_LEN_BYTES = 4;
    localparam int INT_WIDTH     = 32;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BYTES   = 475;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;

    // Parse phases of the expected-result predictor.
    typedef enum logic [2:0] {
        SCAN_TAG, STR_LEN, STR_LEN_BYTES, STR_BODY, INT_LEN, INT_BODY, HEADER_DONE
    } t_parse_phase;

    // Idle patterns on the two channels.
    typedef enum logic [1:0] {
        PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH
    } t_pace;

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Predicts the field results of the header byte stream and checks them.
    class field_scoreboard;
        t_out_res     expected_fields[$];
        int unsigned  mismatches;
        int unsigned  results_checked;
        int unsigned  headers_completed;
        t_parse_phase phase;
        logic [2:0]   elem_num;
        logic         is_int;
        logic [2:0]   len_left;
        logic [31:0]  body_left;
        logic [31:0]  int_acc;

        function new();
            mismatches = 0;
            results_checked = 0;
            headers_completed = 0;
            restart();
        endfunction

        function void restart();
            phase = SCAN_TAG;
            elem_num = '0;
            is_int = 1'b0;
            len_left = '0;
            body_left = '0;
            int_acc = '0;
        endfunction

        function void report_mismatch(input string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        // Strings belong to elements 0 and 1, integers to elements 2 and 3.
        function bit field_wanted();
            if (is_int)
                return elem_num == 3'd2 || elem_num == 3'd3;
            return elem_num < 3'd2;
        endfunction

        function void push_result(input logic [1:0] idx, input logic [1:0] kind,
                                  input logic [31:0] val, input logic last,
                                  input logic done);
            t_out_res r;
            r.field_index = idx;
            r.item_kind = kind;
            r.data_value = val;
            r.last_of_field = last;
            r.header_done = done;
            expected_fields.push_back(r);
        endfunction

        // Ends the current element; only a wanted element yields its last result.
        function void close_element(input logic [1:0] kind, input logic [31:0] val);
            bit         wanted;
            logic [2:0] idx;
            wanted = field_wanted();
            idx = elem_num;
            elem_num++;
            phase = (elem_num >= NUM_ELEMENTS) ? HEADER_DONE : SCAN_TAG;
            if (wanted)
                push_result(idx[1:0], kind, val, 1'b1, elem_num >= NUM_ELEMENTS);
        endfunction

        function void length_known();
            if (body_left == 0)
                close_element(KIND_EMPTY, 32'd0);
            else
                phase = STR_BODY;
        endfunction

        // Advances the predictor by one accepted request.
        function void note_byte(input t_in_req req);
            logic [7:0] b;
            logic [6:0] cnt;
            b = req.data_byte;
            if (req.start_of_header)
                restart();
            case (phase)
                SCAN_TAG: begin
                    if (b == TAG_STRING) begin
                        is_int = 1'b0;
                        phase = STR_LEN;
                    end else if (b == TAG_INTEGER) begin
                        is_int = 1'b1;
                        phase = INT_LEN;
                    end
                end
                STR_LEN: begin
                    body_left = '0;
                    if (b[7]) begin
                        // Long form: clamp the count of length bytes.
                        cnt = b[6:0];
                        if (cnt > MAX_LEN_BYTES)
                            cnt = 7'(MAX_LEN_BYTES);
                        if (cnt == 0) begin
                            length_known();
                        end else begin
                            len_left = cnt[2:0];
                            phase = STR_LEN_BYTES;
                        end
                    end else begin
                        body_left = {24'd0, b};
                        length_known();
                    end
                end
                STR_LEN_BYTES: begin
                    body_left = {body_left[23:0], b};
                    if (len_left > 0)
                        len_left--;
                    if (len_left == 0)
                        length_known();
                end
                STR_BODY: begin
                    if (body_left <= 1) begin
                        body_left = '0;
                        close_element(KIND_CHAR, {24'd0, b});
                    end else begin
                        body_left--;
                        if (field_wanted())
                            push_result(elem_num[1:0], KIND_CHAR, {24'd0, b}, 1'b0, 1'b0);
                    end
                end
                INT_LEN: begin
                    int_acc = '0;
                    body_left = {24'd0, b};
                    if (b == 0)
                        close_element(KIND_INT, 32'd0);
                    else
                        phase = INT_BODY;
                end
                INT_BODY: begin
                    // Big-endian accumulation keeps the low 32 bits.
                    int_acc = {int_acc[23:0], b};
                    if (body_left <= 1) begin
                        body_left = '0;
                        close_element(KIND_INT, int_acc);
                    end else begin
                        body_left--;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(input string name, input logic [31:0] got,
                                    input logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(input t_out_res got);
            t_out_res want;
            if (expected_fields.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = expected_fields.pop_front();
            results_checked++;
            if (want.header_done)
                headers_completed++;
            compare_field("field_index", 32'(got.field_index), 32'(want.field_index));
            compare_field("item_kind", 32'(got.item_kind), 32'(want.item_kind));
            compare_field("data_value", got.data_value, want.data_value);
            compare_field("last_of_field", 32'(got.last_of_field), 32'(want.last_of_field));
            compare_field("header_done", 32'(got.header_done), 32'(want.header_done));
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_res o_out_res;

    field_scoreboard sb = new();
    t_in_req         header_bytes[$];
    bit              sof_next;
    t_pace           pace;
    logic            hold_off;
    int unsigned     bytes_accepted = 0;
    int unsigned     cycle_count = 0;

    tlv_header_field_parser_top #(
        .MAX_LENGTH_BYTES(MAX_LEN_BYTES),
        .INTEGER_WIDTH   (INT_WIDTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_res  (o_out_res)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls per pace, forced low during the hold-off.
    always @(posedge i_clk) begin
        if (hold_off)
            i_out_ready <= 1'b0;
        else if (pace == PACE_RECEIVER)
            i_out_ready <= !chance(46);
        else if (pace == PACE_BOTH)
            i_out_ready <= !chance(25);
        else
            i_out_ready <= 1'b1;
    end

    // Long receiver hold-off so the pipeline fills and stalls its input.
    initial begin
        hold_off <= 1'b0;
        wait (bytes_accepted >= 120);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Observe both handshakes at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_res);
            if (i_in_valid && o_in_ready) begin
                sb.note_byte(i_in_req);
                bytes_accepted++;
            end
        end
    end

    // Offers one request, with random idle cycles before it, and waits for acceptance.
    task automatic drive_byte(input t_in_req req);
        while ((pace == PACE_SENDER && chance(46)) || (pace == PACE_BOTH && chance(25))) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic add_byte(input logic [7:0] b);
        t_in_req r;
        r.data_byte = b;
        r.start_of_header = sof_next || chance(1);
        sof_next = 1'b0;
        header_bytes.push_back(r);
    endtask

    task automatic add_noise();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == TAG_STRING || b == TAG_INTEGER)
            b ^= 8'h40;
        add_byte(b);
    endtask

    // String element in short or long form; sometimes a huge length cut by a restart.
    task automatic add_string();
        int          len;
        int          nlb;
        logic [6:0]  cnt;
        logic [31:0] len_field;
        len = chance(85) ? $urandom_range(6) : $urandom_range(40, 7);
        add_byte(TAG_STRING);
        if (chance(60)) begin
            add_byte(8'(len));
        end else begin
            cnt = chance(90) ? 7'($urandom_range(6)) : 7'($urandom_range(127));
            nlb = (cnt > MAX_LEN_BYTES) ? MAX_LEN_BYTES : int'(cnt);
            if (nlb == 0)
                len = 0;
            len_field = 32'(len);
            if (nlb != 0 && chance(5))
                len_field = $urandom;
            add_byte({1'b1, cnt});
            for (int i = nlb - 1; i >= 0; i--)
                add_byte(len_field[8*i +: 8]);
        end
        repeat (len) add_byte(8'($urandom_range(255)));
    endtask

    task automatic add_integer();
        int len;
        len = chance(97) ? $urandom_range(6) : $urandom_range(255, 128);
        add_byte(TAG_INTEGER);
        add_byte(8'(len));
        repeat (len) add_byte(8'($urandom_range(255)));
    endtask

    // Mostly well-formed headers; some truncated, with wrong kinds or trailing bytes.
    task automatic add_header();
        int n_elems;
        bit want_int;
        sof_next = chance(95);
        n_elems = chance(10) ? $urandom_range(3) : 4;
        for (int e = 0; e < n_elems; e++) begin
            repeat ($urandom_range(2)) add_noise();
            want_int = (e >= 2);
            if (chance(12))
                want_int = !want_int;
            if (want_int)
                add_integer();
            else
                add_string();
        end
        if (chance(30))
            repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));
    endtask

    // Main sequence: reset, directed headers, then random phases.
    initial begin
        pace <= PACE_NONE;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First header without a restart marker: empty string in long form with no
        // length bytes, a clamped long-form string, a zero-length integer and an
        // integer longer than 32 bits.
        sof_next = 1'b0;
        add_byte(TAG_STRING);
        add_byte(8'h80);
        add_byte(TAG_STRING);
        add_byte(8'h86);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h01);
        add_byte(8'h41);
        add_byte(TAG_INTEGER);
        add_byte(8'h00);
        add_byte(TAG_INTEGER);
        add_byte(8'h05);
        add_byte(8'hff);
        add_byte(8'h12);
        add_byte(8'h34);
        add_byte(8'h56);
        add_byte(8'h78);
        // Restarted header with wrong kinds for elements 0 and 3, so its completion is not reported.
        sof_next = 1'b1;
        add_byte(TAG_INTEGER);
        add_byte(8'h00);
        add_byte(TAG_STRING);
        add_byte(8'h00);
        add_byte(TAG_INTEGER);
        add_byte(8'h00);
        add_byte(TAG_STRING);
        add_byte(8'h00);
        // Ignored after the fourth element.
        add_byte(TAG_STRING);
        while (header_bytes.size() > 0)
            drive_byte(header_bytes.pop_front());

        for (int p = 0; p < 4; p++) begin
            pace <= t_pace'(p);
            while (header_bytes.size() < PHASE_BYTES)
                add_header();
            while (header_bytes.size() > 0)
                drive_byte(header_bytes.pop_front());
        end
        i_in_valid <= 1'b0;
        pace <= PACE_NONE;

        while (sb.expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d header bytes under four idle patterns and a long output stall",
                  bytes_accepted);
        $display("checked %0d field results, %0d of them completing a header",
                 sb.results_checked, sb.headers_completed);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
